@@ sv/ata_dma_read_command_issuer_macros.svh @@
// assertion macros used by the checker file
`ifndef ATA_DMA_READ_COMMAND_ISSUER_MACROS_SVH
`define ATA_DMA_READ_COMMAND_ISSUER_MACROS_SVH

// antecedent holds in a cycle, consequent must hold in the same cycle
`define ADRI_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// antecedent holds in a cycle, consequent must hold in the next cycle
`define ADRI_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/adri_pkg.sv @@
// ----------------------------------------------------------------------------
// adri_pkg
// shared types and constants for the ata dma read command issuer
// ----------------------------------------------------------------------------
package adri_pkg;

  localparam int MAX_SECTORS_DEF  = 8;
  localparam int SECTOR_BYTES     = 512;
  localparam int CMD_DEPTH_DEF    = 2;

  localparam logic [15:0] CB_PRIMARY   = 16'h01F0;
  localparam logic [15:0] CB_SECONDARY = 16'h0170;

  localparam logic [7:0] DEV_LBA28     = 8'hE0;
  localparam logic [7:0] DEV_LBA48     = 8'h40;
  localparam logic [7:0] CMD_READ_DMA  = 8'hC8;
  localparam logic [7:0] CMD_READ_DMA_EXT = 8'h25;
  localparam logic [7:0] BM_START      = 8'h09;
  localparam logic [7:0] BM_IRQ_CLEAR  = 8'h04;
  localparam logic [7:0] BM_STOP       = 8'h00;

  // task-file register offsets from the controller base
  localparam logic [15:0] TF_COUNT  = 16'd2;
  localparam logic [15:0] TF_LBA0   = 16'd3;
  localparam logic [15:0] TF_LBA1   = 16'd4;
  localparam logic [15:0] TF_LBA2   = 16'd5;
  localparam logic [15:0] TF_DEVICE = 16'd6;
  localparam logic [15:0] TF_CMD    = 16'd7;

  // bus master register offsets
  localparam logic [15:0] BM_REG_CMD    = 16'd0;
  localparam logic [15:0] BM_REG_STATUS = 16'd2;

  typedef enum logic [2:0] {
    KIND_TASKFILE  = 3'd0,
    KIND_BUSMASTER = 3'd1,
    KIND_COUNT     = 3'd2,
    KIND_REJECT    = 3'd3,
    KIND_IGNORE    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    RUN_REJECT,
    RUN_IGNORE,
    RUN_IRQ,
    RUN_LBA28,
    RUN_LBA48
  } run_t;

  typedef struct packed {
    logic        mode;
    logic [1:0]  drive;
    logic [47:0] lba;
    logic [7:0]  sector_count;
    logic        irq_channel;
    logic [7:0]  bm_status;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] port;
    logic [12:0] value;
    logic        last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    run_t        run;
    logic        cont;
    logic        slave;
    logic [47:0] lba;
    logic [7:0]  count;
  } cmd_t;

endpackage

@@ sv/adri_front.sv @@
// ----------------------------------------------------------------------------
// adri_front
// classifies requests and interrupt events, tracks controller busy bits
// ----------------------------------------------------------------------------
module adri_front import adri_pkg::*; #(
  parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t request,
  output cmd_t     cmd
);

  logic [1:0] busy;
  logic [1:0] busy_next;
  logic       cont;
  logic       over_limit;
  logic       big_lba;

  assign cont       = request.drive[1];
  assign over_limit = request.sector_count > 8'(MAX_SECTORS);
  assign big_lba    = |request.lba[47:28];

  always_comb begin
    busy_next = busy;
    cmd.cont  = cont;
    cmd.slave = request.drive[0];
    cmd.lba   = request.lba;
    cmd.count = request.sector_count;
    if (request.mode) begin
      cmd.cont = request.irq_channel;
      if (request.bm_status[2]) begin
        cmd.run = RUN_IRQ;
        busy_next[request.irq_channel] = 1'b0;
      end else begin
        cmd.run = RUN_IGNORE;
      end
    end else if (over_limit || busy[cont]) begin
      cmd.run = RUN_REJECT;
    end else begin
      cmd.run = big_lba ? RUN_LBA48 : RUN_LBA28;
      busy_next[cont] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (accept) begin
      busy <= busy_next;
    end
  end

endmodule

@@ sv/adri_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// adri_cmd_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module adri_cmd_fifo import adri_pkg::*; #(
  parameter int DEPTH = CMD_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_data,
  input  logic rd,
  output cmd_t rd_data,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/adri_back.sv @@
// ----------------------------------------------------------------------------
// adri_back
// sequencer that expands one command into its run of output items
// ----------------------------------------------------------------------------
module adri_back import adri_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] bus_master_base,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_done,
  output out_item_t   result,
  output logic        empty,
  input  logic        pop
);

  typedef enum logic [3:0] {
    ST_COUNT, ST_DEV, ST_HCNT, ST_HLBA0, ST_HLBA1, ST_HLBA2,
    ST_LCNT, ST_LBA0, ST_LBA1, ST_LBA2, ST_CMD, ST_START
  } step_t;

  step_t       step;
  step_t       step_next;
  logic        out_valid;
  logic        load;
  out_item_t   res;
  logic [15:0] cb;
  logic [15:0] bm_base;
  logic        is48;
  logic [7:0]  slave_bit;

  assign load     = cmd_valid && (!out_valid || pop);
  assign cmd_done = load && res.last;
  assign empty    = !out_valid;
  assign cb       = cmd.cont ? CB_SECONDARY : CB_PRIMARY;
  assign bm_base  = {bus_master_base[15:1], 1'b0} + {12'd0, cmd.cont, 3'd0};
  assign is48     = cmd.run == RUN_LBA48;
  assign slave_bit = {3'd0, cmd.slave, 4'd0};

  always_comb begin
    res = '{kind: KIND_TASKFILE, port: '0, value: '0, last: 1'b0};
    case (cmd.run)
      RUN_REJECT: begin
        res.kind = KIND_REJECT;
        res.last = 1'b1;
      end
      RUN_IGNORE: begin
        res.kind = KIND_IGNORE;
        res.last = 1'b1;
      end
      RUN_IRQ: begin
        res.kind = KIND_BUSMASTER;
        if (step == ST_COUNT) begin
          res.port  = bm_base + BM_REG_STATUS;
          res.value = 13'(BM_IRQ_CLEAR);
        end else begin
          res.port  = bm_base + BM_REG_CMD;
          res.value = 13'(BM_STOP);
          res.last  = 1'b1;
        end
      end
      default: begin
        case (step)
          ST_COUNT: begin
            res.kind  = KIND_COUNT;
            res.value = 13'(32'(cmd.count) * SECTOR_BYTES);
          end
          ST_DEV: begin
            res.port  = cb + TF_DEVICE;
            res.value = is48 ? 13'(DEV_LBA48 | slave_bit)
                             : 13'(DEV_LBA28 | slave_bit | {4'd0, cmd.lba[27:24]});
          end
          ST_HCNT: res.port = cb + TF_COUNT;
          ST_HLBA0: begin
            res.port  = cb + TF_LBA0;
            res.value = 13'(cmd.lba[31:24]);
          end
          ST_HLBA1: begin
            res.port  = cb + TF_LBA1;
            res.value = 13'(cmd.lba[39:32]);
          end
          ST_HLBA2: begin
            res.port  = cb + TF_LBA2;
            res.value = 13'(cmd.lba[47:40]);
          end
          ST_LCNT: begin
            res.port  = cb + TF_COUNT;
            res.value = 13'(cmd.count);
          end
          ST_LBA0: begin
            res.port  = cb + TF_LBA0;
            res.value = 13'(cmd.lba[7:0]);
          end
          ST_LBA1: begin
            res.port  = cb + TF_LBA1;
            res.value = 13'(cmd.lba[15:8]);
          end
          ST_LBA2: begin
            res.port  = cb + TF_LBA2;
            res.value = 13'(cmd.lba[23:16]);
          end
          ST_CMD: begin
            res.port  = cb + TF_CMD;
            res.value = is48 ? 13'(CMD_READ_DMA_EXT) : 13'(CMD_READ_DMA);
          end
          ST_START: begin
            res.kind  = KIND_BUSMASTER;
            res.port  = bm_base + BM_REG_CMD;
            res.value = 13'(BM_START);
            res.last  = 1'b1;
          end
          default: res.last = 1'b1;
        endcase
      end
    endcase
  end

  // lba28 skips the high-order task-file writes
  always_comb begin
    if (res.last) begin
      step_next = ST_COUNT;
    end else if (step == ST_DEV && !is48) begin
      step_next = ST_LCNT;
    end else begin
      step_next = step_t'(step + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_COUNT;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= step_next;
        result    <= res;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/ata_dma_read_command_issuer.sv @@
// a taken request is queued first, and the back then registers its first result
// throughput: one result per cycle while pop keeps up; a read request expands to 8
//   (lba28) or 12 (lba48) results, an interrupt to two, other items to one
// reset: rst clears the busy bits, command queue and output register; the
//   bus master base register resets to zero
// ----------------------------------------------------------------------------
// ata_dma_read_command_issuer
// turns dma read requests and controller interrupts into port write runs
// ----------------------------------------------------------------------------
module ata_dma_read_command_issuer import adri_pkg::*; #(
  parameter int MAX_SECTORS = MAX_SECTORS_DEF,
  parameter int CMD_DEPTH   = CMD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  in_item_t    request,
  // result side
  output logic        empty,
  input  logic        pop,
  output out_item_t   result,
  // configuration
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  // bus master base, bit 0 is dropped where ports are formed
  logic [15:0] bus_master_base;

  // front to queue
  logic accept;
  cmd_t front_cmd;

  // queue to back
  cmd_t queue_cmd;
  logic queue_empty;
  logic cmd_done;

  // an item is taken whenever the command queue has room
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_master_base <= '0;
    end else if (cfg_we) begin
      bus_master_base <= cfg_data;
    end
  end

  // front: classify and update the busy bits at accept time, so a later
  // request sees the busy bit of an earlier one even while it is queued
  adri_front #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .request (request),
    .cmd     (front_cmd)
  );

  // short queue lets the front keep taking items while the back works
  adri_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_data (front_cmd),
    .rd      (cmd_done),
    .rd_data (queue_cmd),
    .full    (full),
    .empty   (queue_empty)
  );

  // back: one write per cycle into the output register while it is free or popped
  adri_back u_back (
    .clk             (clk),
    .rst             (rst),
    .bus_master_base (bus_master_base),
    .cmd             (queue_cmd),
    .cmd_valid       (!queue_empty),
    .cmd_done        (cmd_done),
    .result          (result),
    .empty           (empty),
    .pop             (pop)
  );

endmodule

@@ sv/adri_checker.sv @@
// ----------------------------------------------------------------------------
// adri_checker
// port-level checks on the result stream of the command issuer
// ----------------------------------------------------------------------------
`include "ata_dma_read_command_issuer_macros.svh"

module adri_checker import adri_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input out_item_t   result
);

  // a waiting item holds until taken
  `ADRI_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(result))

  // reset leaves both sides empty and open
  `ADRI_ASSERT_NEXT(a_reset, clk, 1'b0, rst, empty && !full)

  // rejected and ignored items are runs of one
  `ADRI_ASSERT_SAME(a_single, clk, rst,
    !empty && (result.kind == KIND_REJECT || result.kind == KIND_IGNORE), result.last)

  // the descriptor count opens a run and carries no port
  `ADRI_ASSERT_SAME(a_count, clk, rst,
    !empty && result.kind == KIND_COUNT, !result.last && result.port == 16'd0)

endmodule

bind ata_dma_read_command_issuer adri_checker u_checker (.*);
